### rtl/core/dtq_pkg.sv
// dtq_pkg: shared constants, codes and controller/datapath interface types
// for the deadline timer queue. No dependencies.
package dtq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_BITS  = 64;
	localparam int IDX_W      = $clog2(NUM_TIMERS);

	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_CANCEL  = 3'd1;
	localparam logic [2:0] CMD_REFRESH = 3'd2;
	localparam logic [2:0] CMD_RESET   = 3'd3;
	localparam logic [2:0] CMD_TICK    = 3'd4;
	localparam logic [2:0] CMD_QUERY   = 3'd5;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic latch;
		logic apply;
		logic idx_clr;
		logic scan_clr;
		logic scan_step;
		logic scan_due;
		logic due_step;
		logic sel;
		logic post;
		logic reload_step;
		logic emit_one;
		logic emit_step;
	} dtq_ctl_t;

	typedef struct packed {
		logic is_tick;
		logic idx_last;
		logic found;
		logic ocnt_zero;
		logic list_last;
	} dtq_sts_t;

endpackage

### rtl/core/dtq_datapath.sv
// dtq_datapath: timer table, tick counter, min-deadline scan unit,
// expiry list and result registers. Depends on dtq_pkg.
module dtq_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtq_pkg::dtq_ctl_t    ctl,
	output dtq_pkg::dtq_sts_t    sts,
	input  logic [2:0]           cmd,
	input  logic [3:0]           slot,
	input  logic [31:0]          period,
	input  logic                 repeat_req,
	input  logic                 restart_now,
	output logic                 done,
	output logic [1:0]           status,
	output logic [3:0]           slot_id,
	output logic                 expired_valid,
	output logic                 last,
	output logic [31:0]          remaining,
	output logic                 front_notice,
	output logic                 any_pending
);
	import dtq_pkg::*;

	localparam int N  = NUM_TIMERS;
	localparam int IW = IDX_W;
	localparam int TW = TIME_BITS;

	logic [2:0]    cmd_q;
	logic [3:0]    slot_q;
	logic [31:0]   per_q;
	logic          rep_q;
	logic          fnow_q;

	logic [TW-1:0] now_q;
	logic [TW-1:0] dl_q [N];
	logic [31:0]   ps_q [N];
	logic [N-1:0]  rf_q;
	logic [N-1:0]  pend_q;
	logic [N-1:0]  live_q;
	logic [N-1:0]  due_q;
	logic          note_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic [TW-1:0] best_dl_q;
	logic          found_q;
	logic [IW-1:0] order_q [N];
	logic [IW:0]   ocnt_q;
	logic          enq_q;
	logic [IW-1:0] target_q;

	logic [1:0]    res_status_q;
	logic [3:0]    res_slot_q;
	logic          res_note_q;
	logic [31:0]   rem_q;

	logic          free_found;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] sidx;
	logic          inr;
	logic          add_ok, can_ok, ref_ok, rst_same, rst_ok;
	logic          cand;
	logic [TW-1:0] cur_dl;
	logic          note_hit;
	logic [TW-1:0] diff;
	logic [31:0]   rem_calc;
	logic [IW-1:0] t_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign inr      = {28'd0, slot_q} < 32'(N);
	assign sidx     = inr ? IW'(slot_q) : '0;
	assign add_ok   = (cmd_q == CMD_ADD) && free_found;
	assign can_ok   = (cmd_q == CMD_CANCEL) && inr && live_q[sidx];
	assign ref_ok   = (cmd_q == CMD_REFRESH) && inr && live_q[sidx] && pend_q[sidx];
	assign rst_same = inr && (per_q == ps_q[sidx]) && !fnow_q;
	assign rst_ok   = (cmd_q == CMD_RESET) && inr && !rst_same && live_q[sidx] && pend_q[sidx];

	assign cur_dl   = dl_q[idx_q];
	assign cand     = (ctl.scan_due ? due_q[idx_q] : pend_q[idx_q])
	                  && (!found_q || cur_dl < best_dl_q);
	assign note_hit = enq_q && found_q && (best_q == target_q) && !note_q;
	assign t_idx    = order_q[idx_q];

	// saturating distance to the earliest deadline
	always_comb begin
		diff = best_dl_q - now_q;
		if (!found_q)
			rem_calc = 32'hFFFF_FFFF;
		else if (now_q >= best_dl_q)
			rem_calc = 32'd0;
		else if (diff > TW'(32'hFFFF_FFFF))
			rem_calc = 32'hFFFF_FFFF;
		else
			rem_calc = 32'(diff);
	end

	assign sts.is_tick   = (cmd_q == CMD_TICK);
	assign sts.idx_last  = (idx_q == IW'(N - 1));
	assign sts.found     = found_q;
	assign sts.ocnt_zero = (ocnt_q == '0);
	assign sts.list_last = ({1'b0, idx_q} == (ocnt_q - 1'b1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			pend_q    <= '0;
			live_q    <= '0;
			due_q     <= '0;
			note_q    <= 1'b0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			ocnt_q    <= '0;
			enq_q     <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= ctl.emit_one || ctl.emit_step;
			if (ctl.idx_clr)
				idx_q <= '0;
			else if (ctl.scan_step || ctl.due_step || ctl.reload_step || ctl.emit_step)
				idx_q <= idx_q + 1'b1;
			if (ctl.scan_clr)
				found_q <= 1'b0;
			else if (ctl.scan_step && cand)
				found_q <= 1'b1;
			if (ctl.apply) begin
				ocnt_q <= '0;
				enq_q  <= add_ok || rst_ok;
				if (add_ok) begin
					live_q[free_idx] <= 1'b1;
					pend_q[free_idx] <= 1'b1;
				end
				if (can_ok) begin
					live_q[sidx] <= 1'b0;
					pend_q[sidx] <= 1'b0;
				end
				if (cmd_q == CMD_TICK)
					now_q <= now_q + 1'b1;
			end
			if (ctl.due_step)
				due_q[idx_q] <= pend_q[idx_q] && (cur_dl <= now_q);
			if (ctl.sel && found_q) begin
				due_q[best_q] <= 1'b0;
				ocnt_q        <= ocnt_q + 1'b1;
			end
			if (ctl.reload_step)
				pend_q[t_idx] <= rf_q[t_idx];
			if (ctl.post) begin
				if (cmd_q == CMD_QUERY)
					note_q <= 1'b0;
				else if (note_hit)
					note_q <= 1'b1;
			end
		end
	end

	// table payload and result registers
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd;
			slot_q <= slot;
			per_q  <= period;
			rep_q  <= repeat_req;
			fnow_q <= restart_now;
		end
		if (ctl.scan_step && cand) begin
			best_q    <= idx_q;
			best_dl_q <= cur_dl;
		end
		if (ctl.apply) begin
			target_q   <= add_ok ? free_idx : sidx;
			res_note_q <= 1'b0;
			rem_q      <= '0;
			if (add_ok) begin
				ps_q[free_idx] <= per_q;
				rf_q[free_idx] <= rep_q;
				dl_q[free_idx] <= now_q + TW'(per_q);
			end
			if (ref_ok)
				dl_q[sidx] <= now_q + TW'(ps_q[sidx]);
			if (rst_ok) begin
				ps_q[sidx] <= per_q;
				if (fnow_q)
					dl_q[sidx] <= now_q + TW'(per_q);
				else
					dl_q[sidx] <= dl_q[sidx] + TW'(per_q) - TW'(ps_q[sidx]);
			end
			case (cmd_q)
				CMD_ADD: begin
					res_status_q <= free_found ? ST_DONE : ST_FULL;
					res_slot_q   <= free_found ? 4'(free_idx) : 4'd0;
				end
				CMD_CANCEL: begin
					res_status_q <= (can_ok && pend_q[sidx]) ? ST_DONE : ST_REFUSED;
					res_slot_q   <= slot_q;
				end
				CMD_REFRESH: begin
					res_status_q <= ref_ok ? ST_DONE : ST_REFUSED;
					res_slot_q   <= slot_q;
				end
				CMD_RESET: begin
					res_status_q <= (rst_ok || rst_same) ? ST_DONE : ST_REFUSED;
					res_slot_q   <= slot_q;
				end
				CMD_TICK, CMD_QUERY: begin
					res_status_q <= ST_DONE;
					res_slot_q   <= 4'd0;
				end
				default: begin
					res_status_q <= ST_REFUSED;
					res_slot_q   <= 4'd0;
				end
			endcase
		end
		if (ctl.sel && found_q)
			order_q[ocnt_q[IW-1:0]] <= best_q;
		if (ctl.reload_step && rf_q[t_idx])
			dl_q[t_idx] <= now_q + TW'(ps_q[t_idx]);
		if (ctl.post) begin
			if (cmd_q == CMD_QUERY)
				rem_q <= rem_calc;
			else if (note_hit)
				res_note_q <= 1'b1;
		end
		if (ctl.emit_one) begin
			status        <= res_status_q;
			slot_id       <= res_slot_q;
			expired_valid <= 1'b0;
			last          <= 1'b1;
			remaining     <= rem_q;
			front_notice  <= res_note_q;
			any_pending   <= |pend_q;
		end else if (ctl.emit_step) begin
			status        <= ST_DONE;
			slot_id       <= 4'(t_idx);
			expired_valid <= 1'b1;
			last          <= sts.list_last;
			remaining     <= '0;
			front_notice  <= 1'b0;
			any_pending   <= |pend_q;
		end
	end

endmodule

### rtl/core/dtq_ctrl.sv
// dtq_ctrl: command sequencer for the timer queue datapath.
// Depends on dtq_pkg.
module dtq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  dtq_pkg::dtq_sts_t    sts,
	output dtq_pkg::dtq_ctl_t    ctl
);
	import dtq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_APPLY, S_SCAN, S_POST, S_EMIT1,
		S_DUE, S_SCLR, S_SSCAN, S_SEL, S_RELOAD, S_EMITS
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE:   ctl.latch = start;
			S_APPLY: begin
				ctl.apply    = 1'b1;
				ctl.idx_clr  = 1'b1;
				ctl.scan_clr = 1'b1;
			end
			S_SCAN:   ctl.scan_step = 1'b1;
			S_POST:   ctl.post = 1'b1;
			S_EMIT1:  ctl.emit_one = 1'b1;
			S_DUE:    ctl.due_step = 1'b1;
			S_SCLR: begin
				ctl.idx_clr  = 1'b1;
				ctl.scan_clr = 1'b1;
			end
			S_SSCAN: begin
				ctl.scan_step = 1'b1;
				ctl.scan_due  = 1'b1;
			end
			S_SEL: begin
				ctl.sel     = 1'b1;
				ctl.idx_clr = !sts.found;
			end
			S_RELOAD: begin
				ctl.reload_step = 1'b1;
				ctl.idx_clr     = sts.list_last;
			end
			S_EMITS:  ctl.emit_step = 1'b1;
			default:  ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (start) state_q <= S_APPLY;
				S_APPLY:  state_q <= sts.is_tick ? S_DUE : S_SCAN;
				S_SCAN:   if (sts.idx_last) state_q <= S_POST;
				S_POST:   state_q <= S_EMIT1;
				S_EMIT1:  state_q <= S_IDLE;
				S_DUE:    if (sts.idx_last) state_q <= S_SCLR;
				S_SCLR:   state_q <= S_SSCAN;
				S_SSCAN:  if (sts.idx_last) state_q <= S_SEL;
				S_SEL: begin
					if (sts.found)
						state_q <= S_SCLR;
					else
						state_q <= sts.ocnt_zero ? S_EMIT1 : S_RELOAD;
				end
				S_RELOAD: if (sts.list_last) state_q <= S_EMITS;
				S_EMITS:  if (sts.list_last) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/deadline_timer_queue.sv
// Deadline timer queue: NUM_TIMERS timers, one item at a time.
// Non-tick items: one serial min-deadline scan (one slot per cycle), then post.
// Tick: a due pass, then min-deadline scans that pick the expired timers in
// deadline order, then a reload pass; results leave on consecutive cycles.
// Results are strobed by done for one cycle; the receiver cannot stall.
// arst_n clears time, pending/live flags and the controller; no clearing pass.
module deadline_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [3:0]  slot,
	input  logic [31:0] period,
	input  logic        repeat_req,
	input  logic        restart_now,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  slot_id,
	output logic        expired_valid,
	output logic        last,
	output logic [31:0] remaining,
	output logic        front_notice,
	output logic        any_pending
);
	import dtq_pkg::*;

	dtq_ctl_t ctl;
	dtq_sts_t sts;

	dtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	dtq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.slot          (slot),
		.period        (period),
		.repeat_req    (repeat_req),
		.restart_now   (restart_now),
		.done          (done),
		.status        (status),
		.slot_id       (slot_id),
		.expired_valid (expired_valid),
		.last          (last),
		.remaining     (remaining),
		.front_notice  (front_notice),
		.any_pending   (any_pending)
	);

endmodule
